[rtl/core/oled_page_framebuffer_streamer_unit_defines.svh]
// assertion macros for the page-mode framebuffer streamer
// no dependencies; included by the modules that carry checks
`ifndef OLED_PAGE_FRAMEBUFFER_STREAMER_UNIT_DEFINES_SVH
`define OLED_PAGE_FRAMEBUFFER_STREAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OPFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define OPFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define OPFS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define OPFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/opfs_pkg.sv]
// shared types, codes and helper functions of the framebuffer streamer
// no dependencies
`default_nettype none
package opfs_pkg;

   localparam int COLUMNS_DEF     = 128;
   localparam int MAX_ROWS_DEF    = 64;
   localparam int CHUNK_BYTES_DEF = 32;

   localparam logic [7:0] CTRL_COMMANDS    = 8'h00;
   localparam logic [7:0] CTRL_DATA        = 8'h40;
   localparam logic [7:0] OP_COLUMN_WINDOW = 8'h21;
   localparam logic [7:0] OP_PAGE_WINDOW   = 8'h22;
   localparam logic [2:0] WINDOW_LAST      = 3'h6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_READY = 2'd1;
   localparam logic [1:0] ST_DONE      = 2'd2;

   localparam logic [1:0] REG_PANEL_64 = 2'd0;
   localparam logic [1:0] REG_READY    = 2'd1;
   localparam logic [1:0] REG_BUS_ADDR = 2'd2;

   localparam logic [6:0] BUS_ADDR_RESET = 7'd60;

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_BEGIN = 2'd2,
      CMD_CHUNK = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_DRAW   = 3'd0,
      OP_CLEAR  = 3'd1,
      OP_WINDOW = 3'd2,
      OP_CHUNK  = 3'd3,
      OP_REFUSE = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] x;
      logic [2:0] page;
      logic [2:0] bit_sel;
      logic       pixel_on;
   } entry_type;

   function automatic logic [3:0] page_count(input logic is_64, input logic [3:0] max_pages);
      logic [3:0] p;
      p = is_64 ? 4'd8 : 4'd4;
      if (p > max_pages) p = max_pages;
      return p;
   endfunction

   function automatic logic [7:0] window_byte(input logic [2:0] k, input logic [7:0] col_last,
                                              input logic [7:0] page_last);
      logic [7:0] b;
      case (k)
         3'd0:    b = CTRL_COMMANDS;
         3'd1:    b = OP_COLUMN_WINDOW;
         3'd2:    b = 8'h00;
         3'd3:    b = col_last;
         3'd4:    b = OP_PAGE_WINDOW;
         3'd5:    b = 8'h00;
         default: b = page_last;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

[rtl/core/opfs_front.sv]
// front end: accepts commands, range-checks draws, classifies into queue entries
// depends on opfs_pkg and the assertion macro header
`include "oled_page_framebuffer_streamer_unit_defines.svh"
`default_nettype none
module opfs_front import opfs_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [6:0] req_x,
   input  wire logic [5:0] req_y,
   input  wire logic       req_pixel_on,
   input  wire logic       cfg_panel_64,
   input  wire logic       cfg_ready,
   input  wire logic       back_clearing,
   input  wire logic       q_ready,
   output logic            q_push,
   output entry_type       q_data
);

   localparam logic [3:0] MAX_PAGES = 4'(MAX_ROWS / 8);

   logic       accept;
   logic       keep;
   logic [3:0] pages;
   logic       in_range;
   logic       seen_ff;
   logic       seen_in;

   assign pages    = page_count(cfg_panel_64, MAX_PAGES);
   assign in_range = ({1'b0, req_x} < 8'(COLUMNS)) && ({1'b0, req_y} < {pages, 3'b000});

   assign req_stall = !q_ready || back_clearing;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && keep;

   always_comb begin
      keep             = 1'b1;
      q_data.x         = req_x;
      q_data.page      = req_y[5:3];
      q_data.bit_sel   = req_y[2:0];
      q_data.pixel_on  = req_pixel_on;
      q_data.op        = OP_DRAW;
      unique case (cmd_type'(req_command))
         CMD_DRAW: begin
            keep = in_range;
         end
         CMD_CLEAR: begin
            q_data.op = OP_CLEAR;
         end
         CMD_BEGIN: begin
            q_data.op = cfg_ready ? OP_WINDOW : OP_REFUSE;
         end
         CMD_CHUNK: begin
            q_data.op = cfg_ready ? OP_CHUNK : OP_REFUSE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // sticky flag of any accepted transaction since reset
   assign seen_in = seen_ff || accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   `OPFS_ASSERT_IMPLY(a_no_push_when_full, clock, reset, !q_ready, !q_push)
   `OPFS_ASSERT_IMPLY(a_no_accept_in_clear, clock, reset, back_clearing, !accept)
   `OPFS_ASSERT_NEXT(a_seen_sticks, clock, reset, accept, seen_ff)

endmodule
`default_nettype wire

[rtl/core/opfs_queue.sv]
// two-entry queue between the front and back ends
// depends on opfs_pkg
`default_nettype none
module opfs_queue import opfs_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   output logic           push_ready,
   output logic           head_valid,
   output entry_type      head_data,
   input  wire logic      pop
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);

   entry_type       slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [PW:0]     count_ff;
   logic [PW:0]     count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != (PW + 1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/opfs_back.sv]
// back end: frame store, draw read-modify-write, clear pass and bus byte streaming
// depends on opfs_pkg and the assertion macro header
`include "oled_page_framebuffer_streamer_unit_defines.svh"
`default_nettype none
module opfs_back import opfs_pkg::*; #(
   parameter int COLUMNS     = COLUMNS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       cfg_panel_64,
   input  wire logic       q_valid,
   input  wire entry_type  q_data,
   output logic            q_pop,
   output logic            clearing,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_byte_value,
   output logic            rsp_first_of_write,
   output logic            rsp_last_of_write,
   output logic [1:0]      rsp_status
);

   localparam int STORE_BYTES     = COLUMNS * (MAX_ROWS / 8);
   localparam int AW              = $clog2(STORE_BYTES);
   localparam int OW              = $clog2(STORE_BYTES + 1);
   localparam int CW              = $clog2(CHUNK_BYTES + 1);
   localparam logic [3:0] MAX_PAGES = 4'(MAX_ROWS / 8);
   localparam logic [7:0] COL_LAST  = 8'(COLUMNS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DRAW_RD,
      S_DRAW_WR,
      S_WINDOW,
      S_CHUNK,
      S_STATUS
   } state_type;

   state_type       state_ff;
   state_type       state_in;
   entry_type       cur_ff;
   entry_type       cur_in;
   logic [AW-1:0]   clr_cnt_ff;
   logic [AW-1:0]   clr_cnt_in;
   logic [2:0]      win_cnt_ff;
   logic [2:0]      win_cnt_in;
   logic [OW-1:0]   send_offset_ff;
   logic [OW-1:0]   send_offset_in;
   logic [CW-1:0]   rd_left_ff;
   logic [CW-1:0]   rd_left_in;
   logic [CW-1:0]   out_left_ff;
   logic [CW-1:0]   out_left_in;
   logic            hdr_done_ff;
   logic            hdr_done_in;
   logic            pend_ff;
   logic            pend_in;
   logic [1:0]      status_ff;
   logic [1:0]      status_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [7:0]      rsp_byte_ff;
   logic [7:0]      rsp_byte_in;
   logic            rsp_first_ff;
   logic            rsp_first_in;
   logic            rsp_last_ff;
   logic            rsp_last_in;
   logic [1:0]      rsp_status_ff;
   logic [1:0]      rsp_status_in;

   logic [7:0]      mem [STORE_BYTES];
   logic [7:0]      rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [7:0]      mem_wdata;
   logic            mem_re;
   logic [AW-1:0]   mem_raddr;

   logic [3:0]      pages;
   logic [OW-1:0]   frame_bytes;
   logic [OW-1:0]   remain;
   logic [AW-1:0]   draw_addr;
   logic [7:0]      draw_mask;
   logic            can_load;
   logic            data_take;

   assign pages       = page_count(cfg_panel_64, MAX_PAGES);
   assign frame_bytes = OW'(32'(pages) * COLUMNS);
   assign remain      = frame_bytes - send_offset_ff;
   assign draw_addr   = AW'(32'(cur_ff.page) * COLUMNS + 32'(cur_ff.x));
   assign draw_mask   = 8'(1) << cur_ff.bit_sel;
   assign can_load    = !rsp_valid_ff || !rsp_stall;
   assign data_take   = (state_ff == S_CHUNK) && hdr_done_ff && pend_ff && can_load;
   assign clearing    = (state_ff == S_CLEAR);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_value     = rsp_byte_ff;
   assign rsp_first_of_write = rsp_first_ff;
   assign rsp_last_of_write  = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      clr_cnt_in     = clr_cnt_ff;
      win_cnt_in     = win_cnt_ff;
      send_offset_in = send_offset_ff;
      rd_left_in     = rd_left_ff;
      out_left_in    = out_left_ff;
      hdr_done_in    = hdr_done_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = draw_addr;
      mem_wdata      = 8'h00;
      mem_re         = 1'b0;
      mem_raddr      = draw_addr;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            if (clr_cnt_ff == AW'(STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               unique case (q_data.op)
                  OP_DRAW: begin
                     state_in = S_DRAW_RD;
                  end
                  OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  OP_WINDOW: begin
                     win_cnt_in     = '0;
                     send_offset_in = '0;
                     state_in       = S_WINDOW;
                  end
                  OP_CHUNK: begin
                     if (send_offset_ff >= frame_bytes) begin
                        status_in = ST_DONE;
                        state_in  = S_STATUS;
                     end else begin
                        if (32'(remain) > CHUNK_BYTES) begin
                           rd_left_in  = CW'(CHUNK_BYTES);
                           out_left_in = CW'(CHUNK_BYTES);
                        end else begin
                           rd_left_in  = CW'(remain);
                           out_left_in = CW'(remain);
                        end
                        hdr_done_in = 1'b0;
                        state_in    = S_CHUNK;
                     end
                  end
                  OP_REFUSE: begin
                     status_in = ST_NOT_READY;
                     state_in  = S_STATUS;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_DRAW_RD: begin
            mem_re   = 1'b1;
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            mem_we    = 1'b1;
            mem_wdata = cur_ff.pixel_on ? (rd_data_ff | draw_mask) : (rd_data_ff & ~draw_mask);
            state_in  = S_IDLE;
         end
         S_WINDOW: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = window_byte(win_cnt_ff, COL_LAST, 8'(pages - 4'd1));
               rsp_first_in  = (win_cnt_ff == 3'd0);
               rsp_last_in   = (win_cnt_ff == WINDOW_LAST);
               rsp_status_in = ST_OK;
               if (win_cnt_ff == WINDOW_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  win_cnt_in = win_cnt_ff + 1'b1;
               end
            end
         end
         S_STATUS: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = 8'h00;
               rsp_first_in  = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         S_CHUNK: begin
            if (can_load && !hdr_done_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = CTRL_DATA;
               rsp_first_in  = 1'b1;
               rsp_last_in   = 1'b0;
               rsp_status_in = ST_OK;
               hdr_done_in   = 1'b1;
            end else if (data_take) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = rd_data_ff;
               rsp_first_in  = 1'b0;
               rsp_last_in   = (out_left_ff == CW'(1));
               rsp_status_in = ST_OK;
               out_left_in   = out_left_ff - 1'b1;
               if (out_left_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
            // read ahead one byte so data leaves at one byte per cycle while rsp_stall is low
            if ((rd_left_ff != '0) && (!pend_ff || data_take)) begin
               mem_re         = 1'b1;
               mem_raddr      = send_offset_ff[AW-1:0];
               send_offset_in = send_offset_ff + 1'b1;
               rd_left_in     = rd_left_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      pend_in = (mem_re && (state_ff == S_CHUNK)) || (pend_ff && !data_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         send_offset_ff <= '0;
         pend_ff        <= 1'b0;
         hdr_done_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         win_cnt_ff     <= '0;
         rd_left_ff     <= '0;
         out_left_ff    <= '0;
         status_ff      <= ST_OK;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         send_offset_ff <= send_offset_in;
         pend_ff        <= pend_in;
         hdr_done_ff    <= hdr_done_in;
         rsp_valid_ff   <= rsp_valid_in;
         win_cnt_ff     <= win_cnt_in;
         rd_left_ff     <= rd_left_in;
         out_left_ff    <= out_left_in;
         status_ff      <= status_in;
      end
      cur_ff        <= cur_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   `OPFS_ASSERT_IMPLY(a_pend_only_in_chunk, clock, reset, pend_ff, state_ff == S_CHUNK)
   `OPFS_ASSERT_IMPLY(a_no_write_in_chunk, clock, reset, mem_we, state_ff != S_CHUNK)
   `OPFS_ASSERT_IMPLY(a_status_single, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_last_ff && !rsp_first_ff)
   `OPFS_ASSERT_NEXT(a_chunk_ends_clean, clock, reset, data_take && (out_left_ff == CW'(1)), (state_ff == S_IDLE) && !pend_ff)
   `OPFS_ASSERT_IMPLY(a_offset_bound, clock, reset, 1'b1, send_offset_ff <= OW'(STORE_BYTES))

endmodule
`default_nettype wire

[rtl/core/oled_page_framebuffer_streamer_unit.sv]
// flow: the back end pops a transaction from the queue in the cycle after acceptance at the
// earliest; a draw then passes the S_DRAW_RD and S_DRAW_WR states, begin frame sends the seven
// window bytes, next chunk a control byte and n <= CHUNK_BYTES data bytes, a status one byte
// throughput: one bus byte per cycle while rsp_stall is low, set by the single store read port
// clear zeroes the store of COLUMNS*MAX_ROWS/8 bytes (1024 by default); after reset the same
// clearing pass runs with req_stall held high; reset is synchronous; depends on opfs_pkg
`default_nettype none
module oled_page_framebuffer_streamer_unit import opfs_pkg::*; #(
   parameter int COLUMNS     = COLUMNS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [6:0] req_x,
   input  wire logic [5:0] req_y,
   input  wire logic       req_pixel_on,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_byte_value,
   output logic            rsp_first_of_write,
   output logic            rsp_last_of_write,
   output logic [6:0]      rsp_device_address,
   output logic [1:0]      rsp_status,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata
);

   logic       panel_64_ff;
   logic       panel_64_in;
   logic       ready_ff;
   logic       ready_in;
   logic [6:0] bus_addr_ff;
   logic [6:0] bus_addr_in;

   logic       q_ready;
   logic       q_push;
   entry_type  q_wdata;
   logic       q_valid;
   entry_type  q_head;
   logic       q_pop;
   logic       clearing;

   always_comb begin
      panel_64_in = panel_64_ff;
      ready_in    = ready_ff;
      bus_addr_in = bus_addr_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PANEL_64: panel_64_in = csr_wdata[0];
            REG_READY:    ready_in    = csr_wdata[0];
            REG_BUS_ADDR: bus_addr_in = csr_wdata;
            default: begin
               panel_64_in = panel_64_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_64_ff <= 1'b1;
         ready_ff    <= 1'b0;
         bus_addr_ff <= BUS_ADDR_RESET;
      end else begin
         panel_64_ff <= panel_64_in;
         ready_ff    <= ready_in;
         bus_addr_ff <= bus_addr_in;
      end
   end

   assign rsp_device_address = bus_addr_ff;

   opfs_front #(
      .COLUMNS  (COLUMNS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_pixel_on  (req_pixel_on),
      .cfg_panel_64  (panel_64_ff),
      .cfg_ready     (ready_ff),
      .back_clearing (clearing),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_data        (q_wdata)
   );

   opfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .push_ready (q_ready),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop)
   );

   opfs_back #(
      .COLUMNS     (COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg_panel_64       (panel_64_ff),
      .q_valid            (q_valid),
      .q_data             (q_head),
      .q_pop              (q_pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_first_of_write (rsp_first_of_write),
      .rsp_last_of_write  (rsp_last_of_write),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire
